FILE: src/depthwise_conv1d_same_pad_assert.svh
// assertion macros used by the front end rtl file
// needs clk_i and rst_ni in the scope of each use
`ifndef DEPTHWISE_CONV1D_SAME_PAD_ASSERT_SVH
`define DEPTHWISE_CONV1D_SAME_PAD_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DWC1D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DWC1D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dwc1d_pkg.sv
// shared constants and types of the depthwise 1-d convolution block
// no dependencies
`timescale 1ns / 1ps

package dwc1d_pkg;

  localparam int DATA_W     = 16;
  localparam int ROW_W      = 6;
  localparam int TAP_W      = 3;
  localparam int COL_W      = 10;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int FRAC_SHIFT = 14;

  localparam int ROWS_DEF     = 64;
  localparam int TAPS_DEF     = 5;
  localparam int MAX_COLS_DEF = 1024;

  // request function codes
  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // result bookkeeping that travels beside the window data
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             row_done;
  } dwc1d_tag_t;

endpackage

FILE: src/dwc1d_if.sv
// valid/ready channel interfaces for requests and results
// depends on dwc1d_pkg
`timescale 1ns / 1ps

interface dwc1d_in_if;
  import dwc1d_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ROW_W-1:0]         row;
  logic [TAP_W-1:0]         tap;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, func, row, tap, value, last, input ready);
  modport sink   (input valid, func, row, tap, value, last, output ready);
endinterface

interface dwc1d_out_if;
  import dwc1d_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         column;
  logic                     row_done;

  modport source (output valid, result, out_row, column, row_done, input ready);
  modport sink   (input valid, result, out_row, column, row_done, output ready);
endinterface

FILE: src/dwc1d_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dwc1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dwc1d_front.sv
// request front end: weight rams, sample history, column count and flush stepping
// depends on dwc1d_pkg, dwc1d_in_if, dwc1d_ram and the assertion header
`timescale 1ns / 1ps
`include "depthwise_conv1d_same_pad_assert.svh"

module dwc1d_front #(
  parameter int ROWS     = dwc1d_pkg::ROWS_DEF,
  parameter int TAPS     = dwc1d_pkg::TAPS_DEF,
  parameter int MAX_COLS = dwc1d_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dwc1d_in_if.sink                           in_i,
  output logic                               step_valid_o,
  input  logic                               step_ready_i,
  output dwc1d_pkg::dwc1d_tag_t              tag_o,
  output logic signed [dwc1d_pkg::DATA_W-1:0] samp_o [TAPS],
  output logic signed [dwc1d_pkg::DATA_W-1:0] wgt_o  [TAPS]
);
  import dwc1d_pkg::*;

  localparam int HALF   = (TAPS - 1) / 2;
  localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = $clog2(2 * MAX_COLS);
  localparam int STEP_W = $clog2(HALF + 1);
  localparam int NW     = ((CW + 1) > COL_W) ? (CW + 1) : COL_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'(2 * MAX_COLS - 1);

  // input decode
  logic [ROW_W+AW-1:0] row_ext;
  logic [AW-1:0]       row_addr;
  logic                row_ok;
  logic                accept;
  logic                samp_acc;
  logic                wr_acc;

  // history of the current row, oldest at index zero
  logic signed [DATA_W-1:0] hist_q [TAPS-1];
  logic [CW-1:0]            cnt_q;

  // held sample window and flush sequencer
  logic                     s1_v_q;
  logic                     s1_last_q;
  logic                     s1_ok_q;
  logic [ROW_W-1:0]         s1_row_q;
  logic [CW-1:0]            s1_n_q;
  logic [STEP_W-1:0]        s1_step_q;
  logic signed [DATA_W-1:0] win_q [TAPS];

  logic             s1_final;
  logic             s1_adv;
  logic [NW-1:0]    nd;
  logic [NW-1:0]    col_full;
  logic [DATA_W-1:0] rdata [TAPS];

  assign row_ext  = {{AW{1'b0}}, in_i.row};
  assign row_addr = row_ext[AW-1:0];
  assign row_ok   = (row_ext < (ROW_W + AW)'(ROWS));

  assign s1_final = !s1_last_q || (s1_step_q == STEP_W'(HALF));
  assign s1_adv   = s1_v_q && step_ready_i;
  assign in_i.ready = !s1_v_q || (s1_adv && s1_final);

  assign accept   = in_i.valid && in_i.ready;
  assign samp_acc = accept && (in_i.func == FUNC_SAMPLE);
  assign wr_acc   = accept && (in_i.func == FUNC_WEIGHT) && row_ok;

  // one ram per tap so all taps of a kernel row read in parallel
  for (genvar c = 0; c < TAPS; c++) begin : g_tap
    dwc1d_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ROWS),
      .AW    (AW)
    ) u_wram (
      .clk_i   (clk_i),
      .we_i    (wr_acc && (32'(in_i.tap) == c)),
      .waddr_i (row_addr),
      .wdata_i (in_i.value),
      .re_i    (samp_acc),
      .raddr_i (row_addr),
      .rdata_o (rdata[c])
    );

    // rows beyond the table read as zero weights
    assign wgt_o[c]  = s1_ok_q ? $signed(rdata[c]) : '0;
    assign samp_o[c] = win_q[c];
  end

  // column bookkeeping
  always_comb begin
    nd       = NW'(s1_n_q) + NW'(s1_step_q);
    col_full = nd - NW'(HALF);
  end

  assign step_valid_o   = s1_v_q && (nd >= NW'(HALF));
  assign tag_o.row      = s1_row_q;
  assign tag_o.column   = col_full[COL_W-1:0];
  assign tag_o.row_done = s1_last_q && (s1_step_q == STEP_W'(HALF));

  // row history and sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int k = 0; k < TAPS - 1; k++) begin
        hist_q[k] <= '0;
      end
    end else if (samp_acc) begin
      if (in_i.last) begin
        cnt_q <= '0;
        for (int k = 0; k < TAPS - 1; k++) begin
          hist_q[k] <= '0;
        end
      end else begin
        if (cnt_q < COUNT_MAX) begin
          cnt_q <= cnt_q + CW'(1);
        end
        for (int k = 0; k < TAPS - 2; k++) begin
          hist_q[k] <= hist_q[k+1];
        end
        hist_q[TAPS-2] <= in_i.value;
      end
    end
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_step_q <= '0;
    end else if (samp_acc) begin
      s1_v_q    <= 1'b1;
      s1_step_q <= '0;
    end else if (s1_adv) begin
      if (s1_final) begin
        s1_v_q <= 1'b0;
      end else begin
        s1_step_q <= s1_step_q + STEP_W'(1);
      end
    end
  end

  // stage payload; flush steps slide the window toward zero padding
  always_ff @(posedge clk_i) begin
    if (samp_acc) begin
      s1_last_q <= in_i.last;
      s1_ok_q   <= row_ok;
      s1_row_q  <= in_i.row;
      s1_n_q    <= cnt_q;
      for (int k = 0; k < TAPS - 1; k++) begin
        win_q[k] <= hist_q[k];
      end
      win_q[TAPS-1] <= in_i.value;
    end else if (s1_adv && !s1_final) begin
      for (int k = 0; k < TAPS - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[TAPS-1] <= '0;
    end
  end

  `DWC1D_ASSERT_IMP(a_flush_blocks, s1_v_q && !s1_final, !in_i.ready,
    "request taken while a flush is still stepping")
  `DWC1D_ASSERT_IMP(a_step_range, s1_v_q, s1_step_q <= STEP_W'(HALF),
    "flush step beyond half kernel")
  `DWC1D_ASSERT_IMP(a_single_step, s1_v_q && !s1_last_q, s1_step_q == '0,
    "non-final sample took more than one step")
  `DWC1D_ASSERT_NXT(a_row_restart, samp_acc && in_i.last,
    cnt_q == '0 && hist_q[TAPS-2] == '0, "row state not cleared after final sample")

endmodule

FILE: src/dwc1d_mac.sv
// multiply stage, sum with floor shift and saturation, result register
// depends on dwc1d_pkg and dwc1d_out_if
`timescale 1ns / 1ps

module dwc1d_mac #(
  parameter int TAPS = dwc1d_pkg::TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_valid_i,
  output logic                                step_ready_o,
  input  dwc1d_pkg::dwc1d_tag_t               tag_i,
  input  logic signed [dwc1d_pkg::DATA_W-1:0] samp_i [TAPS],
  input  logic signed [dwc1d_pkg::DATA_W-1:0] wgt_i  [TAPS],
  dwc1d_out_if.source                         out_o
);
  import dwc1d_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  logic                     s2_v_q;
  dwc1d_tag_t               s2_tag_q;
  logic signed [PROD_W-1:0] prod_q [TAPS];

  logic                     out_v_q;
  logic signed [DATA_W-1:0] res_q;
  dwc1d_tag_t               out_tag_q;

  logic                     out_free;
  logic                     s2_adv;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [DATA_W-1:0] res_d;

  assign out_free     = !out_v_q || out_o.ready;
  assign s2_adv       = s2_v_q && out_free;
  assign step_ready_o = !s2_v_q || s2_adv;

  // sum of products, floor shift, clamp to 16 bits
  always_comb begin
    acc = '0;
    for (int c = 0; c < TAPS; c++) begin
      acc = acc + ACC_W'(prod_q[c]);
    end
    acc_sh = acc >>> FRAC_SHIFT;
    if (acc_sh > SAT_HI) begin
      res_d = 16'sh7fff;
    end else if (acc_sh < SAT_LO) begin
      res_d = 16'sh8000;
    end else begin
      res_d = acc_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (step_ready_o) begin
        s2_v_q <= step_valid_i;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_ready_o && step_valid_i) begin
      s2_tag_q <= tag_i;
      for (int c = 0; c < TAPS; c++) begin
        prod_q[c] <= samp_i[c] * wgt_i[c];
      end
    end
    if (s2_adv) begin
      res_q     <= res_d;
      out_tag_q <= s2_tag_q;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.result   = res_q;
  assign out_o.out_row  = out_tag_q.row;
  assign out_o.column   = out_tag_q.column;
  assign out_o.row_done = out_tag_q.row_done;

endmodule

FILE: src/depthwise_conv1d_same_pad.sv
// a sample's window, its products and its clamped sum are registered in turn
// throughput: one request per cycle unless the output stalls; a final sample holds
//   the front while its padded flush columns step through the multipliers
// reset: asynchronous, clears the pipeline, the row history and the column count;
//   the weight rams are not cleared and need no clearing pass
// depends on dwc1d_pkg, dwc1d_if, dwc1d_front and dwc1d_mac
`timescale 1ns / 1ps

module depthwise_conv1d_same_pad #(
  parameter int ROWS     = dwc1d_pkg::ROWS_DEF,
  parameter int TAPS     = dwc1d_pkg::TAPS_DEF,
  parameter int MAX_COLS = dwc1d_pkg::MAX_COLS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dwc1d_in_if.sink     in_i,
  dwc1d_out_if.source  out_o
);
  import dwc1d_pkg::*;

  // front to multiply stage: one window step per cycle while the multiply stage accepts,
  // bubbles for columns that would fall before the start of the row
  logic                     step_valid;
  logic                     step_ready;
  dwc1d_tag_t               step_tag;
  logic signed [DATA_W-1:0] step_samp [TAPS];
  logic signed [DATA_W-1:0] step_wgt  [TAPS];

  // weight writes, sample history, per-row column count and the flush
  // sequencer; the kernel row is read from per-tap rams on sample requests
  dwc1d_front #(
    .ROWS     (ROWS),
    .TAPS     (TAPS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .step_valid_o (step_valid),
    .step_ready_i (step_ready),
    .tag_o        (step_tag),
    .samp_o       (step_samp),
    .wgt_o        (step_wgt)
  );

  // TAPS parallel 16x16 multipliers, registered, then the adder, the floor
  // shift by 14 and the 16-bit clamp into the result register
  dwc1d_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (step_valid),
    .step_ready_o (step_ready),
    .tag_i        (step_tag),
    .samp_i       (step_samp),
    .wgt_i        (step_wgt),
    .out_o        (out_o)
  );

endmodule
